>>> sv/ssc_pkg.sv
// Shared types, constants and the CRC-32 byte step for the save image checker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ssc_pkg;

    // Header layout and limits
    localparam int unsigned HDR_BYTES          = 24;
    localparam int unsigned HDR_IDX_W          = 5;
    localparam int unsigned COUNT_W            = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [31:0] HDR_MAGIC          = 32'h534E_4346;
    localparam logic [15:0] HDR_VERSION        = 16'd1;
    localparam int unsigned DEF_MAX_PAYLOAD    = 65536;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY           = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT           = 32'hFFFF_FFFF;

    // Configuration port
    localparam int unsigned CFG_ADDR_W         = 3;
    localparam logic        REG_ROM_CRC        = 1'b0;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_TRUNCATED    = 4'd1,
        ST_MAGIC        = 4'd2,
        ST_VERSION      = 4'd3,
        ST_HEADER       = 4'd4,
        ST_PAYLOAD_SIZE = 4'd5,
        ST_LENGTH       = 4'd6,
        ST_ROM          = 4'd7,
        ST_CHECKSUM     = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] payload_length;
    } t_out_item;

    // Advance the CRC by one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/save_image_stream_checker_core.sv
// Top level of the save image stream checker: input register, checker state,
// result register and register port. Depends on ssc_pkg, ssc_cfg and ssc_chk.
`timescale 1ns / 1ps

// Takes one image byte per clock, except while the input side stalls as below,
// and keeps taking them indefinitely. The verdict is registered: the byte marked
// last is held in the input register and its verdict is loaded into the result
// register as it leaves. Each byte is checked between the input register and the
// result register, where the CRC-32 byte step and the header compares sit.
// The input side stalls only when a last byte waits for a result register that
// still holds an untaken result. Write expected_rom_crc while no image is in
// flight; header bytes are not cleared at reset and every verdict reads only
// bytes of the current image.
module save_image_stream_checker_core #(
    parameter int unsigned MAX_PAYLOAD_BYTES = ssc_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  ssc_pkg::t_in_item              i_in,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output ssc_pkg::t_out_item             o_out,
    input  logic                           i_out_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ssc_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        w_out_free;
    logic        w_fire;
    logic        w_take;
    logic [31:0] w_rom_crc;
    t_out_item   w_result;

    ssc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_rom_crc (w_rom_crc)
    );

    ssc_chk #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in),
        .i_rom_crc (w_rom_crc),
        .o_result  (w_result)
    );

    // Advance a held byte unless it is a last byte with nowhere to put its result
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (!r_in.last || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_take     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in;
        end
    end

    // Result register: load on a last byte, drop once transferred out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in.last && r_out_valid)
        else $error("input stalled without a blocked last byte");

    a_result_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in.last |=> o_out_valid)
        else $error("last byte gave no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or vanished");

endmodule

>>> sv/ssc_cfg.sv
// APB-style register port for the save image checker: holds the expected ROM CRC.
// Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [31:0]                    o_rom_crc
);
    import ssc_pkg::*;

    logic [31:0] r_rom_crc;
    logic        w_sel_rom;

    // Decode the word address
    assign w_sel_rom = (paddr[2] == REG_ROM_CRC);
    assign pready    = 1'b1;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_crc <= '0;
        end else if (psel && penable && pwrite && w_sel_rom) begin
            r_rom_crc <= pwdata;
        end
    end

    // Read back
    always_comb begin
        prdata = w_sel_rom ? r_rom_crc : 32'd0;
    end

    assign o_rom_crc = r_rom_crc;

endmodule

>>> sv/ssc_chk.sv
// Per-byte state of the save image checker: byte count, header bytes, running CRC,
// and the end-of-image verdict. Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_chk #(
    parameter int unsigned MAX_PAYLOAD_BYTES = ssc_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ssc_pkg::t_in_item   i_item,
    input  logic [31:0]         i_rom_crc,
    output ssc_pkg::t_out_item  o_result
);
    import ssc_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [31:0]        r_crc;
    logic [31:0]        n_crc;
    logic [7:0]         r_hdr [HDR_BYTES];
    logic [7:0]         w_hdr [HDR_BYTES];
    logic               w_in_hdr;
    logic [COUNT_W-1:0] w_total;
    logic [31:0]        w_crc_upd;
    logic [31:0]        w_magic;
    logic [15:0]        w_version;
    logic [15:0]        w_hdr_size;
    logic [31:0]        w_rom;
    logic [31:0]        w_payload;
    logic [31:0]        w_pay_crc;
    logic [31:0]        w_reserved;
    logic [32:0]        w_expect_total;

    assign w_in_hdr = (r_count < COUNT_W'(HDR_BYTES));

    // Count with saturation
    assign w_total = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    // CRC covers only bytes after the header
    assign w_crc_upd = w_in_hdr ? r_crc : crc_byte(r_crc, i_item.data_byte);

    // Merge the byte being written so the verdict sees the full header
    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            w_hdr[k] = (w_in_hdr && r_count[HDR_IDX_W-1:0] == HDR_IDX_W'(k))
                     ? i_item.data_byte : r_hdr[k];
        end
    end

    // Little-endian header fields
    assign w_magic    = {w_hdr[3],  w_hdr[2],  w_hdr[1],  w_hdr[0]};
    assign w_version  = {w_hdr[5],  w_hdr[4]};
    assign w_hdr_size = {w_hdr[7],  w_hdr[6]};
    assign w_rom      = {w_hdr[11], w_hdr[10], w_hdr[9],  w_hdr[8]};
    assign w_payload  = {w_hdr[15], w_hdr[14], w_hdr[13], w_hdr[12]};
    assign w_pay_crc  = {w_hdr[19], w_hdr[18], w_hdr[17], w_hdr[16]};
    assign w_reserved = {w_hdr[23], w_hdr[22], w_hdr[21], w_hdr[20]};

    assign w_expect_total = 33'(HDR_BYTES) + {1'b0, w_payload};

    // Verdict: first failing check decides
    always_comb begin
        o_result.status         = ST_OK;
        o_result.payload_length = '0;
        if (w_total < COUNT_W'(HDR_BYTES)) begin
            o_result.status = ST_TRUNCATED;
        end else if (w_magic != HDR_MAGIC) begin
            o_result.status = ST_MAGIC;
        end else if (w_version != HDR_VERSION) begin
            o_result.status = ST_VERSION;
        end else if (w_hdr_size != 16'(HDR_BYTES) || w_reserved != 32'd0) begin
            o_result.status = ST_HEADER;
        end else if (w_payload == 32'd0 ||
                     {1'b0, w_payload} > 33'(MAX_PAYLOAD_BYTES)) begin
            o_result.status = ST_PAYLOAD_SIZE;
        end else if (w_total == COUNT_MAX || {16'd0, w_total} != w_expect_total) begin
            o_result.status = ST_LENGTH;
        end else if (w_rom != i_rom_crc) begin
            o_result.status = ST_ROM;
        end else if (~w_crc_upd != w_pay_crc) begin
            o_result.status = ST_CHECKSUM;
        end else begin
            o_result.payload_length = w_payload[COUNT_W-1:0];
        end
    end

    // Next count and CRC: restart after the last byte
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (i_fire) begin
            n_count = i_item.last ? '0 : w_total;
            n_crc   = i_item.last ? CRC_INIT : w_crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // Capture header bytes
    always_ff @(posedge i_clk) begin
        if (i_fire && w_in_hdr) begin
            r_hdr[r_count[HDR_IDX_W-1:0]] <= i_item.data_byte;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.last |=> (r_count == '0) && (r_crc == CRC_INIT))
        else $error("count or CRC not restarted after last byte");

    a_len_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.payload_length != '0 |-> o_result.status == ST_OK)
        else $error("payload length reported with a failing status");

    a_hdr_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !w_in_hdr && !i_item.last |=> r_count >= COUNT_W'(HDR_BYTES))
        else $error("byte count fell back into the header");

endmodule
